// ----- src/ssim_pkg.sv -----
`default_nettype none

package ssim_pkg;

	// Sequencer states of the store controller.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_MRG_RD,
		ST_MRG_CMP,
		ST_RESP
	} state_t;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_INS_A = 2'd0;
	localparam logic [1:0] CMD_INS_B = 2'd1;
	localparam logic [1:0] CMD_MERGE = 2'd2;

	// Status codes on the output channel.
	localparam logic [1:0] STAT_INSERTED = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_ITEM     = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	localparam int unsigned VAL_W = 32;

	// Signed greater-than on raw 32-bit store words.
	function automatic logic sgt(input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y);
		return $signed(x) > $signed(y);
	endfunction

endpackage

`default_nettype wire

// ----- src/sorted_store_insert_merge_top.sv -----
`default_nettype none

// Two ascending sorted stores, A and B, of signed 32-bit values.
// Input channel (in_valid/in_stall, command, value): command 0 inserts value
// into store A, command 1 into store B, command 2 asks for a merge, and
// command 3 is taken and ignored. Output channel (out_valid/out_stall,
// status, item, last) carries the result words.
// An insert gives one word: inserted, or full when the store already holds
// CAPACITY values (the value is then dropped). Each stored value larger than
// the new one is read and written one place up through the memory ports,
// one per cycle.
// A merge gives every value of both stores in ascending order, one word per
// cycle while the output is not stalled, after a read start-up state;
// last marks the final word. Two empty stores give a single empty word.
// The stores are not changed by a merge. The block works on one command
// at a time.
// Reset clears both fill counts, so both stores start empty; the memory
// contents need no clearing. A stall on the output simply holds the word
// in the output register and pauses the sequencer until it is taken.
module sorted_store_insert_merge_top
	import ssim_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      item,
	output logic                    last
);

	// Count width holds CAPACITY itself, address width indexes the stores.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t state_q, state_d;

	// Fill counts and command context.
	logic [CW-1:0]    cnt_a_q, cnt_b_q;
	logic             sel_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    ia_q, ib_q;
	logic [1:0]       rsp_q;

	// Output register.
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] item_q;
	logic             last_q;

	// Memory ports.
	logic             a_we, b_we;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr_a, rd_addr_b;
	logic [VAL_W-1:0] rd_a, rd_b;

	// Control from the output decoder.
	logic             accept;
	logic             out_free;
	logic             out_load;
	logic [1:0]       out_status_d;
	logic [VAL_W-1:0] out_item_d;
	logic             out_last_d;
	logic             ins_we;
	logic             cnt_inc;
	logic             idx_dec;
	logic             mrg_adv;
	logic             rsp_load;
	logic [1:0]       rsp_d;

	// Shared decode terms.
	logic [CW-1:0]    n_sel;
	logic             sel_full;
	logic             both_empty;
	logic [CW-1:0]    idx_m1, idx_m2;
	logic [VAL_W-1:0] rd_sel;
	logic             shift_up;
	logic             take_a;
	logic [CW-1:0]    ia_n, ib_n;
	logic             mrg_done;

	ssim_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr_a),
		.rdata (rd_a)
	);

	ssim_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr_b),
		.rdata (rd_b)
	);

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign n_sel      = command[0] ? cnt_b_q : cnt_a_q;
	assign sel_full   = (n_sel >= CW'(CAPACITY));
	assign both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
	assign idx_m1     = idx_q - CW'(1);
	assign idx_m2     = idx_q - CW'(2);

	// During an insert the walk goes from the top entry down; an entry larger
	// than the new value moves one place up, the first one that is not
	// larger leaves its upper neighbor free for the new value.
	assign rd_sel   = sel_q ? rd_b : rd_a;
	assign shift_up = sgt(rd_sel, val_q);

	// Merge pick: store A wins when store B is used up, else only when its head is
	// strictly smaller, so that equal heads leave store B first.
	assign take_a   = (ia_q < cnt_a_q) && ((ib_q >= cnt_b_q) || sgt(rd_b, rd_a));
	assign ia_n     = ia_q + CW'(take_a);
	assign ib_n     = ib_q + CW'(!take_a);
	assign mrg_done = (ia_n == cnt_a_q) && (ib_n == cnt_b_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (command == CMD_INS_A || command == CMD_INS_B) begin
						state_d = sel_full ? ST_RESP : ST_INS_RD;
					end else if (command == CMD_MERGE) begin
						state_d = both_empty ? ST_RESP : ST_MRG_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_INS_RD: begin
				state_d = (idx_q == '0) ? ST_RESP : ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (shift_up) begin
					state_d = (idx_q == CW'(1)) ? ST_INS_RD : ST_INS_CMP;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_MRG_RD: begin
				state_d = ST_MRG_CMP;
			end
			ST_MRG_CMP: begin
				if (out_free && mrg_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		ins_we       = 1'b0;
		wr_addr      = idx_q[AW-1:0];
		wr_data      = val_q;
		rd_addr_a    = ia_q[AW-1:0];
		rd_addr_b    = ib_q[AW-1:0];
		out_load     = 1'b0;
		out_status_d = rsp_q;
		out_item_d   = '0;
		out_last_d   = 1'b1;
		cnt_inc      = 1'b0;
		idx_dec      = 1'b0;
		mrg_adv      = 1'b0;
		rsp_load     = 1'b0;
		rsp_d        = STAT_INSERTED;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((command == CMD_INS_A || command == CMD_INS_B) && sel_full) begin
						rsp_load = 1'b1;
						rsp_d    = STAT_FULL;
					end else if (command == CMD_MERGE && both_empty) begin
						rsp_load = 1'b1;
						rsp_d    = STAT_EMPTY;
					end
				end
			end
			ST_INS_RD: begin
				if (idx_q == '0) begin
					ins_we   = 1'b1;
					wr_addr  = '0;
					cnt_inc  = 1'b1;
					rsp_load = 1'b1;
				end else begin
					rd_addr_a = idx_m1[AW-1:0];
					rd_addr_b = idx_m1[AW-1:0];
				end
			end
			ST_INS_CMP: begin
				ins_we = 1'b1;
				if (shift_up) begin
					wr_data   = rd_sel;
					idx_dec   = 1'b1;
					rd_addr_a = idx_m2[AW-1:0];
					rd_addr_b = idx_m2[AW-1:0];
				end else begin
					cnt_inc  = 1'b1;
					rsp_load = 1'b1;
				end
			end
			ST_MRG_RD: begin
				// Pointers are zero here; the heads arrive in the next cycle.
			end
			ST_MRG_CMP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = STAT_ITEM;
					out_item_d   = take_a ? rd_a : rd_b;
					out_last_d   = mrg_done;
					mrg_adv      = 1'b1;
					rd_addr_a    = ia_n[AW-1:0];
					rd_addr_b    = ib_n[AW-1:0];
				end
			end
			ST_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	assign a_we = ins_we && !sel_q;
	assign b_we = ins_we && sel_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc && !sel_q) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (cnt_inc && sel_q) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	// Command context and output words.
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= command[0];
			val_q <= value;
			idx_q <= n_sel;
			ia_q  <= '0;
			ib_q  <= '0;
		end
		if (idx_dec) begin
			idx_q <= idx_m1;
		end
		if (mrg_adv) begin
			ia_q <= ia_n;
			ib_q <= ib_n;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (out_load) begin
			status_q <= out_status_d;
			item_q   <= out_item_d;
			last_q   <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- src/ssim_ram.sv -----
`default_nettype none

module ssim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
